// File: design/plbq_pkg.sv
// Shared types and constants for the price-level book best-quote unit.
`default_nettype none

package plbq_pkg;

  localparam int unsigned MaxLevels = 16384;
  localparam int unsigned QtyWidth  = 32;
  localparam int unsigned LvlW      = 14;
  localparam int unsigned QtyInW    = 32;

  localparam logic [LvlW-1:0] CfgLevelsReset = 14'd100;

  localparam logic SideBid = 1'b0;
  localparam logic SideAsk = 1'b1;

  typedef enum logic [1:0] {
    KIND_DELTA = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_SNAP  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0]               kind;
    logic                     side;
    logic [LvlW-1:0]          price;
    logic signed [QtyInW-1:0] quantity;
  } item_t;

  typedef struct packed {
    logic [LvlW-1:0] best_bid;
    logic [LvlW-1:0] best_ask;
    logic            range_error;
  } res_t;

endpackage

`default_nettype wire

// File: design/price_level_book_best_quote_unit.sv
// Steps: accept, MAP, DONE, output register for snapshot, unused or out-of-range; a delta adds ADD after MAP.
// A delta that empties its level then passes SCAN and CHK per level examined, and SCAN once more at the bound.
// Throughput: one transaction at a time; tready returns as the result is registered.
// A clear transaction sweeps the level memory, one entry a cycle, before its result is returned.
// Reset clears control state, then a sweep zeroes the memory with tready low.
// The output register lets the next transaction start while a result waits to be taken.
`default_nettype none

module price_level_book_best_quote_unit #(
  parameter int unsigned MAX_LEVELS = plbq_pkg::MaxLevels,
  parameter int unsigned QTY_WIDTH  = plbq_pkg::QtyWidth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [13:0] cfg_wdata_i,     // levels_in_use
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,    // price[13:0], quantity[45:14], zero pad
  input  wire logic [2:0]  s_axis_tuser,    // kind[1:0], side[2]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,    // best_bid[13:0], best_ask[27:14], zero pad
  output logic             m_axis_tuser     // range_error
);

  localparam int unsigned AW = $clog2(MAX_LEVELS);

  logic [plbq_pkg::LvlW-1:0] cfg_levels_q;
  logic                      out_valid_q;
  plbq_pkg::res_t            out_res_q;

  plbq_pkg::item_t  in_item;
  plbq_pkg::res_t   res;
  logic             res_valid;
  logic             res_ready;
  logic             mem_we;
  logic [AW-1:0]    mem_addr;
  logic [QTY_WIDTH-1:0] mem_wdata;
  logic [QTY_WIDTH-1:0] mem_rdata;

  assign in_item.kind     = s_axis_tuser[1:0];
  assign in_item.side     = s_axis_tuser[2];
  assign in_item.price    = s_axis_tdata[13:0];
  assign in_item.quantity = s_axis_tdata[45:14];

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_levels_q <= plbq_pkg::CfgLevelsReset;
      out_valid_q  <= 1'b0;
      out_res_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        cfg_levels_q <= cfg_wdata_i;
      end
      if (res_valid) begin
        out_valid_q <= 1'b1;
        out_res_q   <= res;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_res_q.best_ask, out_res_q.best_bid};
  assign m_axis_tuser  = out_res_q.range_error;

  plbq_ctrl #(
    .MAX_LEVELS(MAX_LEVELS),
    .QTY_WIDTH (QTY_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (in_item),
    .cfg_levels_i(cfg_levels_q),
    .mem_we_o    (mem_we),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata),
    .res_ready_i (res_ready),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  plbq_level_ram #(
    .DEPTH(MAX_LEVELS),
    .WIDTH(QTY_WIDTH)
  ) u_level_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

endmodule

`default_nettype wire

// File: design/plbq_level_ram.sv
// Level quantity memory: one write or read port, registered read data.
`default_nettype none

module plbq_level_ram #(
  parameter int unsigned DEPTH = plbq_pkg::MaxLevels,
  parameter int unsigned WIDTH = plbq_pkg::QtyWidth
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

// File: design/plbq_ctrl.sv
// Sequencer with a quantity adder and best-price step unit.
`default_nettype none

module plbq_ctrl #(
  parameter int unsigned MAX_LEVELS = plbq_pkg::MaxLevels,
  parameter int unsigned QTY_WIDTH  = plbq_pkg::QtyWidth
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire plbq_pkg::item_t                in_item_i,
  input  wire logic [plbq_pkg::LvlW-1:0]      cfg_levels_i,
  output logic                                mem_we_o,
  output logic [$clog2(MAX_LEVELS)-1:0]       mem_addr_o,
  output logic [QTY_WIDTH-1:0]                mem_wdata_o,
  input  wire logic [QTY_WIDTH-1:0]           mem_rdata_i,
  input  wire logic                           res_ready_i,
  output logic                                res_valid_o,
  output plbq_pkg::res_t                      res_o
);

  localparam int unsigned AW = $clog2(MAX_LEVELS);
  localparam logic [AW-1:0] LastAddr = AW'(MAX_LEVELS - 1);
  localparam int unsigned LW = plbq_pkg::LvlW;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_MAP,
    ST_ADD,
    ST_SCAN,
    ST_CHK,
    ST_DONE
  } state_e;

  state_e              state_q;
  plbq_pkg::item_t     item_q;
  logic [LW-1:0]       lvl_q;
  logic [LW-1:0]       bid_q;
  logic [LW-1:0]       ask_q;
  logic                err_q;
  logic                clr_item_q;
  logic [AW-1:0]       sweep_q;

  logic [LW-1:0]        eff_l;
  logic [LW-1:0]        map_lvl;
  logic                 map_err;
  logic [QTY_WIDTH-1:0] qext;
  logic [QTY_WIDTH-1:0] sum;
  logic                 bid_more;
  logic                 ask_more;
  logic                 bid_in_mem;
  logic                 ask_in_mem;

  assign eff_l = (32'(cfg_levels_i) > MAX_LEVELS) ? LW'(MAX_LEVELS) : cfg_levels_i;

  always_comb begin
    if (item_q.side == plbq_pkg::SideBid) begin
      map_err = item_q.price >= eff_l;
      map_lvl = item_q.price;
    end else begin
      map_err = (item_q.price == '0) || (item_q.price > eff_l);
      map_lvl = eff_l - item_q.price;
    end
  end

  assign qext       = QTY_WIDTH'(item_q.quantity);
  assign sum        = mem_rdata_i + qext;
  assign bid_more   = bid_q > LW'(1);
  assign ask_more   = ({1'b0, ask_q} + (LW + 1)'(1)) < {1'b0, eff_l};
  assign bid_in_mem = 32'(bid_q) < MAX_LEVELS;
  assign ask_in_mem = 32'(ask_q) < MAX_LEVELS;

  always_comb begin
    mem_we_o    = 1'b0;
    mem_addr_o  = sweep_q;
    mem_wdata_o = '0;
    case (state_q)
      ST_CLR: begin
        mem_we_o = 1'b1;
      end
      ST_MAP: begin
        mem_addr_o  = AW'(map_lvl);
        mem_we_o    = (item_q.kind == plbq_pkg::KIND_SNAP) && !map_err;
        mem_wdata_o = qext;
      end
      ST_ADD: begin
        mem_addr_o  = AW'(lvl_q);
        mem_we_o    = 1'b1;
        mem_wdata_o = sum;
      end
      ST_SCAN: begin
        mem_addr_o = (item_q.side == plbq_pkg::SideBid) ? AW'(bid_q) : AW'(ask_q);
      end
      default: begin
        mem_we_o = 1'b0;
      end
    endcase
  end

  assign in_ready_o        = state_q == ST_IDLE;
  assign res_valid_o       = (state_q == ST_DONE) && res_ready_i;
  assign res_o.best_bid    = bid_q;
  assign res_o.best_ask    = ask_q;
  assign res_o.range_error = err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLR;
      item_q     <= '0;
      lvl_q      <= '0;
      bid_q      <= '0;
      ask_q      <= plbq_pkg::CfgLevelsReset;
      err_q      <= 1'b0;
      clr_item_q <= 1'b0;
      sweep_q    <= '0;
    end else begin
      case (state_q)
        ST_CLR: begin
          sweep_q <= sweep_q + AW'(1);
          if (sweep_q == LastAddr) begin
            sweep_q <= '0;
            state_q <= clr_item_q ? ST_DONE : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            item_q  <= in_item_i;
            state_q <= ST_MAP;
          end
        end
        ST_MAP: begin
          err_q <= 1'b0;
          lvl_q <= map_lvl;
          case (item_q.kind)
            plbq_pkg::KIND_CLEAR: begin
              bid_q      <= '0;
              ask_q      <= cfg_levels_i;
              clr_item_q <= 1'b1;
              state_q    <= ST_CLR;
            end
            plbq_pkg::KIND_DELTA: begin
              if (map_err) begin
                err_q   <= 1'b1;
                state_q <= ST_DONE;
              end else begin
                state_q <= ST_ADD;
              end
            end
            plbq_pkg::KIND_SNAP: begin
              if (map_err) begin
                err_q <= 1'b1;
              end else if (item_q.side == plbq_pkg::SideBid) begin
                bid_q <= map_lvl;
              end else begin
                ask_q <= map_lvl;
              end
              state_q <= ST_DONE;
            end
            default: begin
              state_q <= ST_DONE;
            end
          endcase
        end
        ST_ADD: begin
          if (sum == '0) begin
            state_q <= ST_SCAN;
          end else begin
            if (item_q.side == plbq_pkg::SideBid) begin
              if (lvl_q > bid_q) begin
                bid_q <= lvl_q;
              end
            end else if (lvl_q < ask_q) begin
              ask_q <= lvl_q;
            end
            state_q <= ST_DONE;
          end
        end
        ST_SCAN: begin
          if (item_q.side == plbq_pkg::SideBid) begin
            if (!bid_more) begin
              state_q <= ST_DONE;
            end else if (!bid_in_mem) begin
              bid_q <= bid_q - LW'(1);
            end else begin
              state_q <= ST_CHK;
            end
          end else begin
            if (!ask_more) begin
              state_q <= ST_DONE;
            end else if (!ask_in_mem) begin
              ask_q <= ask_q + LW'(1);
            end else begin
              state_q <= ST_CHK;
            end
          end
        end
        ST_CHK: begin
          if (mem_rdata_i == '0) begin
            if (item_q.side == plbq_pkg::SideBid) begin
              bid_q <= bid_q - LW'(1);
            end else begin
              ask_q <= ask_q + LW'(1);
            end
            state_q <= ST_SCAN;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_ready_i) begin
            clr_item_q <= 1'b0;
            state_q    <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  a_we_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> (state_q == ST_CLR || state_q == ST_MAP || state_q == ST_ADD))
    else $error("memory written outside clear, map or add");

  a_chk_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CHK |-> $past(state_q) == ST_SCAN)
    else $error("check without preceding scan read");

  a_add_after_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ADD |-> $past(state_q) == ST_MAP)
    else $error("add without preceding read");

  a_accept_to_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == ST_MAP)
    else $error("accepted transaction not mapped");

  a_result_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> state_q == ST_IDLE)
    else $error("result handed off without return to idle");

endmodule

`default_nettype wire
